// ===== design/gbss_pkg.sv =====
// gbss_pkg: shared types and constants for the gap-bounded span search block
// holds request codes, sequencer states and the per-search context record
// no dependencies
`timescale 1ns / 1ps

package gbss_pkg;

    // field widths fixed by the request format
    localparam int POS_W = 31;
    localparam int IDX_W = 17;
    localparam int RES_W = 32;

    // request function codes (code 3 is unused and ignored)
    typedef enum logic [1:0] {
        FN_APPEND = 2'd0,
        FN_QUERY  = 2'd1,
        FN_CLEAR  = 2'd2
    } t_func;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT
    } t_state;

    // one lower-bound search: window plus the last entries seen on each side
    typedef struct packed {
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] count;
        logic [POS_W-1:0] lt_val;
        logic [POS_W-1:0] ge_val;
        logic             lt_seen;
        logic             ge_seen;
    } t_ctx;

endpackage

// ===== design/gap_bounded_span_search.sv =====
// gap_bounded_span_search: gap position table with predecessor/successor query
// two interleaved binary searches share one table read port and one step unit
// depends on gbss_pkg, gbss_ram, gbss_step
//
//  channel  | handshake        | fields
//  ---------+------------------+-----------------------------------------------
//  request  | start, busy      | i_func, i_position_value, i_start_pos,
//           |                  | i_end_pos, i_slice_first, i_slice_end,
//           |                  | i_seq_length
//  result   | o_valid (strobe) | o_left_pos, o_right_pos, o_span_length
//
// Append and clear requests never raise busy.
// During a query there is one table read per cycle, the lower and upper
// searches alternating on the single read port of the table memory.
// Reset clears the fill count and the sequencer; the table is not cleared.
// The result strobe lasts one cycle and cannot be held off by the receiver.
`timescale 1ns / 1ps

module gap_bounded_span_search
    import gbss_pkg::*;
#(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_func,
    input  logic [POS_W-1:0]        i_position_value,
    input  logic [POS_W-1:0]        i_start_pos,
    input  logic [POS_W-1:0]        i_end_pos,
    input  logic [IDX_W-1:0]        i_slice_first,
    input  logic [IDX_W-1:0]        i_slice_end,
    input  logic [POS_W-1:0]        i_seq_length,
    output logic                    o_valid,
    output logic signed [RES_W-1:0] o_left_pos,
    output logic signed [RES_W-1:0] o_right_pos,
    output logic [POS_W-1:0]        o_span_length
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    t_state r_state, n_state;

    logic [CW-1:0]    r_fill;
    t_ctx             r_ctx_lo, r_ctx_hi;
    logic [POS_W-1:0] r_key_lo, r_key_hi, r_len;
    logic             r_pend;
    logic             r_sel;

    logic                    r_valid;
    logic signed [RES_W-1:0] r_left, r_right;
    logic [POS_W-1:0]        r_span;

    logic             accept;
    logic             do_append, do_clear, do_query;
    logic [IDX_W-1:0] end_clamp;
    logic [IDX_W-1:0] init_count;
    logic [POS_W-1:0] key_lo, key_hi;

    t_ctx             iss_ctx;
    logic             iss_vld;
    logic [IDX_W-1:0] iss_mid;
    logic [POS_W-1:0] rd_data;
    t_ctx             stp_in, stp_out;
    t_ctx             post_lo, post_hi;
    logic             search_done;

    logic                    left_none, right_none;
    logic signed [RES_W-1:0] left_val, right_val;
    logic [POS_W-1:0]        span_a, span_b;
    logic [RES_W-1:0]        span_diff;

    // request decode
    assign busy      = (r_state != ST_IDLE);
    assign accept    = start && !busy;
    assign do_append = accept && (i_func == FN_APPEND) && (r_fill != CW'(TABLE_DEPTH));
    assign do_clear  = accept && (i_func == FN_CLEAR);
    assign do_query  = accept && (i_func == FN_QUERY);

    // order interval ends and clamp the slice to the filled part
    assign key_lo    = (i_start_pos < i_end_pos) ? i_start_pos : i_end_pos;
    assign key_hi    = (i_start_pos < i_end_pos) ? i_end_pos : i_start_pos;
    assign end_clamp = (CMPW'(i_slice_end) > CMPW'(r_fill)) ? IDX_W'(r_fill) : i_slice_end;
    assign init_count = (i_slice_first < end_clamp) ? (end_clamp - i_slice_first)
                                                    : '0;

    // table memory
    gbss_ram #(
        .WIDTH (POS_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (do_append),
        .i_waddr (AW'(r_fill)),
        .i_wdata (i_position_value),
        .i_raddr (AW'(iss_mid)),
        .o_rdata (rd_data)
    );

    // shared probe unit works on the search whose read returned this cycle
    assign stp_in = r_sel ? r_ctx_hi : r_ctx_lo;

    gbss_step u_step (
        .i_ctx  (stp_in),
        .i_key  (r_sel ? r_key_hi : r_key_lo),
        .i_data (rd_data),
        .o_ctx  (stp_out)
    );

    // read issue for the other search, and context values after this cycle
    always_comb begin
        iss_ctx = r_sel ? r_ctx_lo : r_ctx_hi;
        iss_vld = (r_state == ST_SEARCH) && (iss_ctx.count != '0);
        iss_mid = iss_ctx.base + (iss_ctx.count >> 1);
        post_lo = r_ctx_lo;
        post_hi = r_ctx_hi;
        if (r_pend && !r_sel) begin
            post_lo = stp_out;
        end
        if (r_pend && r_sel) begin
            post_hi = stp_out;
        end
        search_done = !iss_vld && (post_lo.count == '0) && (post_hi.count == '0);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (do_query) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (search_done) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // result values from the finished searches
    always_comb begin
        left_none = 1'b1;
        left_val  = '1;
        if (r_ctx_lo.ge_seen && !(r_ctx_lo.ge_val > r_key_lo)) begin
            left_none = 1'b0;
            left_val  = RES_W'({1'b0, r_ctx_lo.ge_val});
        end else if (r_ctx_lo.lt_seen) begin
            left_none = 1'b0;
            left_val  = RES_W'({1'b0, r_ctx_lo.lt_val});
        end
        right_none = !r_ctx_hi.ge_seen;
        right_val  = right_none ? '1 : RES_W'({1'b0, r_ctx_hi.ge_val});
        span_a     = right_none ? r_len : r_ctx_hi.ge_val;
        span_b     = left_none ? '0 : left_val[POS_W-1:0];
        span_diff  = {1'b0, span_a} - {1'b0, span_b};
    end

    // sequencer and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            r_sel   <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_RESULT);
            if (do_clear) begin
                r_fill <= '0;
            end else if (do_append) begin
                r_fill <= r_fill + CW'(1);
            end
            if (do_query) begin
                r_pend <= 1'b0;
                r_sel  <= 1'b1;
            end else if (r_state == ST_SEARCH) begin
                r_pend <= iss_vld;
                r_sel  <= !r_sel;
            end
        end
    end

    // search contexts and query operands
    always_ff @(posedge i_clk) begin
        if (do_query) begin
            r_key_lo         <= key_lo;
            r_key_hi         <= key_hi;
            r_len            <= i_seq_length;
            r_ctx_lo.base    <= i_slice_first;
            r_ctx_lo.count   <= init_count;
            r_ctx_lo.lt_val  <= '0;
            r_ctx_lo.ge_val  <= '0;
            r_ctx_lo.lt_seen <= 1'b0;
            r_ctx_lo.ge_seen <= 1'b0;
            r_ctx_hi.base    <= i_slice_first;
            r_ctx_hi.count   <= init_count;
            r_ctx_hi.lt_val  <= '0;
            r_ctx_hi.ge_val  <= '0;
            r_ctx_hi.lt_seen <= 1'b0;
            r_ctx_hi.ge_seen <= 1'b0;
        end else if (r_state == ST_SEARCH) begin
            r_ctx_lo <= post_lo;
            r_ctx_hi <= post_hi;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RESULT) begin
            r_left  <= left_val;
            r_right <= right_val;
            r_span  <= span_diff[POS_W] ? '0 : span_diff[POS_W-1:0];
        end
    end

    assign o_valid       = r_valid;
    assign o_left_pos    = r_left;
    assign o_right_pos   = r_right;
    assign o_span_length = r_span;

endmodule

// ===== design/gbss_ram.sv =====
// gbss_ram: generic single-write, single-read memory with registered read data
// used for the gap position table
// no dependencies
`timescale 1ns / 1ps

module gbss_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/gbss_step.sv =====
// gbss_step: shared compare-and-narrow unit, one binary search probe per use
// advances one search context from the entry read at its midpoint
// depends on gbss_pkg
`timescale 1ns / 1ps

module gbss_step
    import gbss_pkg::*;
(
    input  t_ctx             i_ctx,
    input  logic [POS_W-1:0] i_key,
    input  logic [POS_W-1:0] i_data,
    output t_ctx             o_ctx
);

    logic [IDX_W-1:0] half;
    logic [IDX_W-1:0] mid;

    assign half = i_ctx.count >> 1;
    assign mid  = i_ctx.base + half;

    // entry below key moves the window up, otherwise it shrinks to the lower half
    always_comb begin
        o_ctx = i_ctx;
        if (i_data < i_key) begin
            o_ctx.base    = mid + IDX_W'(1);
            o_ctx.count   = i_ctx.count - half - IDX_W'(1);
            o_ctx.lt_val  = i_data;
            o_ctx.lt_seen = 1'b1;
        end else begin
            o_ctx.count   = half;
            o_ctx.ge_val  = i_data;
            o_ctx.ge_seen = 1'b1;
        end
    end

endmodule

// ===== test/gap_bounded_span_search_tb.sv =====
// gap_bounded_span_search_tb: self-checking bench for the gap position table search
// drives append, query and clear requests, predicts every query result and checks the strobe
// depends on gbss_pkg and gap_bounded_span_search
`timescale 1ns / 1ps

module gap_bounded_span_search_tb;
    import gbss_pkg::*;

    localparam int TABLE_DEPTH = 65536;
    localparam logic [1:0] FN_UNUSED = 2'd3;
    localparam logic [POS_W-1:0] MAX_POS = '1;
    localparam logic signed [RES_W-1:0] NO_GAP = -1;
    localparam int QUERY_LATENCY = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_REQUESTS = 1350;

    // one query answer
    typedef struct packed {
        logic signed [RES_W-1:0] left;
        logic signed [RES_W-1:0] right;
        logic [POS_W-1:0]        span;
    } t_span_result;

    // one request, with an optional hand-written answer
    typedef struct packed {
        logic [1:0]       func;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] sp;
        logic [POS_W-1:0] ep;
        logic [IDX_W-1:0] first_idx;
        logic [IDX_W-1:0] stop_idx;
        logic [POS_W-1:0] len;
        bit               typed;
        t_span_result     want;
    } t_request;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              i_func = '0;
    logic [POS_W-1:0]        i_position_value = '0;
    logic [POS_W-1:0]        i_start_pos = '0;
    logic [POS_W-1:0]        i_end_pos = '0;
    logic [IDX_W-1:0]        i_slice_first = '0;
    logic [IDX_W-1:0]        i_slice_end = '0;
    logic [POS_W-1:0]        i_seq_length = '0;
    logic                    o_valid;
    logic signed [RES_W-1:0] o_left_pos;
    logic signed [RES_W-1:0] o_right_pos;
    logic [POS_W-1:0]        o_span_length;

    // predictor copy of the table
    bit [POS_W-1:0] gap_copy [TABLE_DEPTH];
    int unsigned    gap_fill = 0;

    t_span_result span_expect_q [$];
    t_request     directed_rows [$];
    int           mismatch_count = 0;
    int           stall_cycles = 0;
    int           idle_pct = 0;
    int           live_requests = 0;

    gap_bounded_span_search dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_position_value (i_position_value),
        .i_start_pos      (i_start_pos),
        .i_end_pos        (i_end_pos),
        .i_slice_first    (i_slice_first),
        .i_slice_end      (i_slice_end),
        .i_seq_length     (i_seq_length),
        .o_valid          (o_valid),
        .o_left_pos       (o_left_pos),
        .o_right_pos      (o_right_pos),
        .o_span_length    (o_span_length)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // first index in [lo_idx, hi_idx) whose entry is not below key
    function automatic int unsigned first_not_below(int unsigned lo_idx, int unsigned hi_idx,
                                                    bit [POS_W-1:0] key);
        int unsigned base;
        int unsigned count;
        int unsigned half;
        base = lo_idx;
        count = hi_idx - lo_idx;
        while (count > 0) begin
            half = count >> 1;
            if (gap_copy[base + half] < key) begin
                base = base + half + 1;
                count = count - half - 1;
            end else begin
                count = half;
            end
        end
        return base;
    endfunction

    // update the table copy; returns 1 when the request yields a query answer
    function automatic bit predict_span(input t_request r, output t_span_result res);
        bit [POS_W-1:0] lo;
        bit [POS_W-1:0] hi;
        int unsigned    first;
        int unsigned    stop;
        int unsigned    idx;
        longint         left;
        longint         right;
        longint         span;
        res = '0;
        if (r.func == FN_APPEND) begin
            if (gap_fill < TABLE_DEPTH) begin
                gap_copy[gap_fill] = r.pos;
                gap_fill++;
            end
            return 1'b0;
        end
        if (r.func == FN_CLEAR) begin
            gap_fill = 0;
            return 1'b0;
        end
        if (r.func != FN_QUERY)
            return 1'b0;

        lo = (r.sp < r.ep) ? r.sp : r.ep;
        hi = (r.sp < r.ep) ? r.ep : r.sp;
        first = r.first_idx;
        stop = (r.stop_idx > gap_fill) ? gap_fill : r.stop_idx;
        left = -1;
        right = -1;
        if (first < stop) begin
            // predecessor, with the last slice entry when lo is above them all
            idx = first_not_below(first, stop, lo);
            if (idx == stop) begin
                left = gap_copy[stop - 1];
            end else if (gap_copy[idx] > lo) begin
                if (idx > first)
                    left = gap_copy[idx - 1];
            end else begin
                left = gap_copy[idx];
            end
            // successor
            idx = first_not_below(first, stop, hi);
            if (idx != stop)
                right = gap_copy[idx];
        end
        span = ((right == -1) ? longint'(r.len) : right) - ((left == -1) ? 0 : left);
        if (span < 0)
            span = 0;
        res.left = 32'(left);
        res.right = 32'(right);
        res.span = 31'(span);
        return 1'b1;
    endfunction

    function automatic t_request make_request(logic [1:0] func, logic [POS_W-1:0] pos,
                                              logic [POS_W-1:0] sp, logic [POS_W-1:0] ep,
                                              logic [IDX_W-1:0] first_idx,
                                              logic [IDX_W-1:0] stop_idx,
                                              logic [POS_W-1:0] len);
        t_request r;
        r = '0;
        r.func = func;
        r.pos = pos;
        r.sp = sp;
        r.ep = ep;
        r.first_idx = first_idx;
        r.stop_idx = stop_idx;
        r.len = len;
        return r;
    endfunction

    function automatic t_request with_answer(t_request r, logic signed [RES_W-1:0] left,
                                             logic signed [RES_W-1:0] right,
                                             logic [POS_W-1:0] span);
        r.typed = 1'b1;
        r.want.left = left;
        r.want.right = right;
        r.want.span = span;
        return r;
    endfunction

    // append one row to the directed table
    function automatic void add_row(t_request r);
        directed_rows = {directed_rows, r};
    endfunction

    function automatic t_request random_fields(logic [1:0] func);
        return make_request(func, 31'($urandom()), 31'($urandom()), 31'($urandom()),
                            17'($urandom_range(TABLE_DEPTH)),
                            17'($urandom_range(TABLE_DEPTH)), 31'($urandom()));
    endfunction

    // search key: extremes, table entries and their neighbors, or anything
    function automatic logic [POS_W-1:0] pick_key();
        longint v;
        case ($urandom_range(5))
            0: return MAX_POS;
            1: return '0;
            2, 3: begin
                if (gap_fill != 0) begin
                    v = longint'(gap_copy[$urandom_range(gap_fill - 1)])
                        + longint'($urandom_range(2)) - 1;
                    if (v < 0)
                        v = 0;
                    if (v > longint'(MAX_POS))
                        v = MAX_POS;
                    return v[POS_W-1:0];
                end
            end
            default: ;
        endcase
        return 31'($urandom());
    endfunction

    // hand one request over, with an optional idle stretch first
    task automatic send_request(input t_request r);
        t_span_result res;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_func = r.func;
        i_position_value = r.pos;
        i_start_pos = r.sp;
        i_end_pos = r.ep;
        i_slice_first = r.first_idx;
        i_slice_end = r.stop_idx;
        i_seq_length = r.len;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        if (predict_span(r, res))
            span_expect_q = {span_expect_q, (r.typed ? r.want : res)};
        if (r.func != FN_UNUSED)
            live_requests++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (span_expect_q.size() != 0)
            @(negedge i_clk);
    endtask

    // query with a slice that is mostly inside the filled part
    task automatic send_query();
        t_request    r;
        int unsigned first;
        int unsigned stop;
        r = random_fields(FN_QUERY);
        case ($urandom_range(19))
            0: begin
                first = TABLE_DEPTH;
                stop = $urandom_range(TABLE_DEPTH);
            end
            1: begin
                first = $urandom_range(gap_fill);
                stop = TABLE_DEPTH;
            end
            2: begin
                first = $urandom_range(gap_fill + 2);
                stop = $urandom_range(first);
            end
            default: begin
                first = $urandom_range(gap_fill);
                stop = $urandom_range(gap_fill, first);
            end
        endcase
        r.first_idx = 17'(first);
        r.stop_idx = 17'(stop);
        r.sp = pick_key();
        r.ep = ($urandom_range(3) == 0) ? r.sp : pick_key();
        case ($urandom_range(3))
            0: r.len = 31'($urandom());
            1: r.len = 31'($urandom_range(100));
            2: r.len = MAX_POS;
            default: r.len = pick_key();
        endcase
        send_request(r);
    endtask

    // one sequence: maybe an unused request, maybe clear, append a mostly ascending run, then query it
    task automatic random_batch();
        int          n_app;
        int          n_qry;
        longint      walk;
        int unsigned stride_cap;
        t_request    r;
        if ($urandom_range(19) == 0)
            send_request(random_fields(FN_UNUSED));
        if ($urandom_range(99) < 80 || gap_fill > 1000)
            send_request(random_fields(FN_CLEAR));
        n_app = ($urandom_range(9) == 0) ? $urandom_range(25, 100) : $urandom_range(24);
        case ($urandom_range(2))
            0: stride_cap = 3;
            1: stride_cap = 1000;
            default: stride_cap = 32'h8000_0000 / (n_app + 1);
        endcase
        case ($urandom_range(2))
            0: walk = 0;
            1: walk = $urandom_range(1000);
            default: walk = $urandom() & 32'h3FFF_FFFF;
        endcase
        for (int i = 0; i < n_app; i++) begin
            r = random_fields(FN_APPEND);
            if ($urandom_range(99) >= 6) begin
                walk += $urandom_range(stride_cap);
                if (walk > longint'(MAX_POS))
                    walk = MAX_POS;
                r.pos = walk[POS_W-1:0];
            end
            send_request(r);
        end
        n_qry = $urandom_range(2, 10);
        for (int i = 0; i < n_qry; i++)
            send_query();
    endtask

    // result checker
    always @(posedge i_clk) begin : result_check
        t_span_result want;
        if (i_rst_n && o_valid) begin
            if (span_expect_q.size() == 0) begin
                $display("%0t: unexpected result left %0d right %0d span %0d",
                         $time, o_left_pos, o_right_pos, o_span_length);
                mismatch_count++;
            end else begin
                want = span_expect_q.pop_front();
                if (o_left_pos !== want.left) begin
                    $display("%0t: left_pos expected %0d got %0d", $time, want.left, o_left_pos);
                    mismatch_count++;
                end
                if (o_right_pos !== want.right) begin
                    $display("%0t: right_pos expected %0d got %0d",
                             $time, want.right, o_right_pos);
                    mismatch_count++;
                end
                if (o_span_length !== want.span) begin
                    $display("%0t: span_length expected %0d got %0d",
                             $time, want.span, o_span_length);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any request or result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        int random_base;

        // directed rows: empty table, small ordered table, extremes, empty slices
        add_row(with_answer(
            make_request(FN_QUERY, 0, 5, 10, 0, TABLE_DEPTH, 100), NO_GAP, NO_GAP, 100));
        add_row(with_answer(
            make_request(FN_QUERY, 0, MAX_POS, 0, 0, 0, MAX_POS), NO_GAP, NO_GAP, MAX_POS));
        add_row(
            make_request(FN_UNUSED, MAX_POS, MAX_POS, MAX_POS, TABLE_DEPTH, TABLE_DEPTH, MAX_POS));
        add_row(make_request(FN_APPEND, 10, 0, 0, 0, 0, 0));
        add_row(make_request(FN_APPEND, 20, 0, 0, 0, 0, 0));
        add_row(make_request(FN_APPEND, 30, 0, 0, 0, 0, 0));
        add_row(make_request(FN_QUERY, 0, 15, 25, 0, 3, 100));
        add_row(make_request(FN_QUERY, 0, 25, 15, 0, 3, 100));
        add_row(make_request(FN_QUERY, 0, 40, 40, 0, 3, 100));
        add_row(make_request(FN_QUERY, 0, 0, 0, 0, 3, 100));
        add_row(make_request(FN_QUERY, 0, 20, 20, 0, 3, 100));
        add_row(make_request(FN_QUERY, 0, 40, 40, 0, 3, 5));
        add_row(make_request(FN_QUERY, 0, 15, 25, 1, TABLE_DEPTH, 100));
        add_row(with_answer(
            make_request(FN_QUERY, 0, 15, 25, 2, 2, 77), NO_GAP, NO_GAP, 77));
        add_row(with_answer(
            make_request(FN_QUERY, 0, 15, 25, 3, 1, 0), NO_GAP, NO_GAP, 0));
        add_row(make_request(FN_APPEND, MAX_POS, 0, 0, 0, 0, 0));
        add_row(make_request(FN_QUERY, 0, MAX_POS, 0, 0, TABLE_DEPTH, 0));
        add_row(make_request(FN_QUERY, 0, MAX_POS, MAX_POS, 0, TABLE_DEPTH, 0));
        add_row(make_request(FN_CLEAR, 0, 0, 0, 0, 0, 0));
        add_row(with_answer(
            make_request(FN_QUERY, 0, 15, 25, 0, TABLE_DEPTH, 100), NO_GAP, NO_GAP, 100));
        // out of order appends
        add_row(make_request(FN_APPEND, 50, 0, 0, 0, 0, 0));
        add_row(make_request(FN_APPEND, 5, 0, 0, 0, 0, 0));
        add_row(make_request(FN_QUERY, 0, 6, 6, 0, 2, 60));
        add_row(make_request(FN_CLEAR, 0, 0, 0, 0, 0, 0));

        // reset
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i]);

        // random sequences in three idling phases, draining between them
        random_base = live_requests;
        idle_pct = 19;
        while (live_requests - random_base < RANDOM_REQUESTS / 3)
            random_batch();
        wait_drained();
        idle_pct = 69;
        while (live_requests - random_base < 2 * RANDOM_REQUESTS / 3)
            random_batch();
        wait_drained();
        idle_pct = 0;
        while (live_requests - random_base < RANDOM_REQUESTS)
            random_batch();

        wait_drained();
        repeat (QUERY_LATENCY) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== gap_bounded_span_search.f =====
design/gbss_pkg.sv
design/gbss_ram.sv
design/gbss_step.sv
design/gap_bounded_span_search.sv
test/gap_bounded_span_search_tb.sv
